### rtl/adm_pkg.sv
// ----------------------------------------------------------------------------
// adm_pkg: shared types and constants of the PCM mono downmix
// Register indexes, controller states and the command and status bundles
// between controller and datapath.
// ----------------------------------------------------------------------------
package adm_pkg;

  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;
  localparam int SampleW   = 32;

  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_BYTES  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_LIMIT   = 2'd2;

  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_DIV  = 3'b010,
    S_WAIT = 3'b100
  } state_e;

  typedef struct packed {
    logic take;      // byte handshake completes this cycle
    logic div_step;  // advance the divider by one quotient bit
    logic out_load;  // move the quotient into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_end; // the offered byte completes a frame
    logic div_last;  // divider is on its final step
    logic out_free;  // output register can take a new result
  } ctrl_status_t;

endpackage

### rtl/adm_if.sv
// ----------------------------------------------------------------------------
// adm_if: stream channels of the PCM mono downmix
// Byte input channel and mono sample output channel, valid/ready.
// ----------------------------------------------------------------------------
interface adm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface adm_mono_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mono_sample;
  logic               last_frame;

  modport source (output valid, output mono_sample, output last_frame, input ready);
  modport sink   (input valid, input mono_sample, input last_frame, output ready);
endinterface

### rtl/aiff_pcm_downmix.sv
// ----------------------------------------------------------------------------
// aiff_pcm_downmix: big-endian PCM to mono downmix
// Assembles 8 to 32 bit big-endian samples into Q1.31, sums the channels of
// each frame and emits the truncated channel average, up to a frame limit.
//
//   channel    direction  carries
//   byte_i     in         data_byte, one sound-data byte per item
//   mono_o     out        mono_sample (Q1.31), last_frame
//   cfg_*_i    in         register writes, index 0..2, no read-back
//
// A byte that does not complete a frame is accepted in the run state. The byte that
// completes a frame starts the restoring divider, which produces one quotient
// bit per cycle over the full sum width, and the result enters the output
// register from the wait state once that register is free; no bytes are taken
// meanwhile. A waiting result does not block bytes of the next frame, only the
// next division's hand-off. Reset restores the register defaults at once;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module aiff_pcm_downmix
  import adm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  adm_byte_if.sink            byte_i,
  adm_mono_if.source          mono_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  adm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_i.valid),
    .in_ready_o (byte_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  adm_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .data_byte_i   (byte_i.data_byte),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (mono_o.ready),
    .out_valid_o   (mono_o.valid),
    .mono_sample_o (mono_o.mono_sample),
    .last_frame_o  (mono_o.last_frame)
  );

endmodule

### rtl/adm_ctrl.sv
// ----------------------------------------------------------------------------
// adm_ctrl: sequencing controller
// Accepts bytes, runs the divider after each completed frame and hands the
// quotient to the output register.
// ----------------------------------------------------------------------------
module adm_ctrl
  import adm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      S_RUN: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && status_i.frame_end) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_RUN;
        end
      end
      default: state_d = S_RUN;
    endcase
  end

  a_ready_only_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_RUN)
    else $error("byte accepted outside the run state");

  a_frame_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take && status_i.frame_end) |=> state_q == S_DIV)
    else $error("completed frame did not start the divider");

  a_load_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (state_q == S_WAIT && status_i.out_free))
    else $error("result loaded while output busy or divider not done");

endmodule

### rtl/adm_dp.sv
// ----------------------------------------------------------------------------
// adm_dp: downmix datapath
// Configuration registers, sample assembly, frame accumulation, a one bit
// per cycle restoring divider and the output register.
// ----------------------------------------------------------------------------
module adm_dp
  import adm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgDataW-1:0]     cfg_wdata_i,
  input  logic [7:0]              data_byte_i,
  input  ctrl_cmd_t               cmd_i,
  output ctrl_status_t            status_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic signed [SampleW-1:0] mono_sample_o,
  output logic                    last_frame_o
);

  // The channel register is four bits wide, so at most fifteen channels count.
  localparam int          ChCapInt = (MAX_CHANNELS > 15) ? 15 : MAX_CHANNELS;
  localparam logic [3:0]  ChCap    = 4'(ChCapInt);
  localparam int          SumW     = SampleW + 1 + $clog2(ChCapInt + 1);
  localparam int          CntW     = $clog2(SumW);
  localparam logic [CntW-1:0] CntLoad = CntW'(SumW - 1);

  logic [3:0]  channel_count_q;
  logic [2:0]  sample_bytes_q;
  logic [31:0] frame_limit_q;

  logic [31:0]            sample_shift_q, sample_shift_d;
  logic [1:0]             byte_idx_q, byte_idx_d;
  logic [3:0]             ch_idx_q, ch_idx_d;
  logic signed [SumW-1:0] frame_sum_q, frame_sum_d;
  logic [31:0]            frames_done_q, frames_done_d;

  logic [SumW-1:0]  dq_q, dq_d;       // dividend bits out, quotient bits in
  logic [4:0]       rem_q, rem_d;
  logic             neg_q, neg_d;
  logic             last_q, last_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic                     out_valid_q;
  logic signed [SampleW-1:0] out_sample_q;
  logic                     out_last_q;

  logic [2:0]             nbytes;
  logic [3:0]             nch;
  logic                   limited;
  logic                   sample_end;
  logic                   frame_end;
  logic [31:0]            shift_new;
  logic [31:0]            just;
  logic signed [SumW-1:0] sum_new;
  logic [5:0]             trial;
  logic                   fits;
  logic [SumW-1:0]        quot_signed;
  logic                   cfg_clear;

  always_comb begin
    nbytes = sample_bytes_q;
    if (sample_bytes_q == 3'd0) nbytes = 3'd1;
    else if (sample_bytes_q > 3'd4) nbytes = 3'd4;
    nch = channel_count_q;
    if (channel_count_q == 4'd0) nch = 4'd1;
    else if (channel_count_q > ChCap) nch = ChCap;
  end

  assign limited    = frames_done_q >= frame_limit_q;
  assign sample_end = ({1'b0, byte_idx_q} + 3'd1) >= nbytes;
  assign frame_end  = !limited && sample_end && (({1'b0, ch_idx_q} + 5'd1) >= {1'b0, nch});
  assign shift_new  = {sample_shift_q[23:0], data_byte_i};

  always_comb begin
    case (nbytes)
      3'd1:    just = {shift_new[7:0], 24'd0};
      3'd2:    just = {shift_new[15:0], 16'd0};
      3'd3:    just = {shift_new[23:0], 8'd0};
      default: just = shift_new;
    endcase
  end

  assign sum_new   = frame_sum_q + SumW'(signed'(just));
  assign cfg_clear = cfg_we_i &&
                     (cfg_idx_i == CFG_CHANNEL_COUNT || cfg_idx_i == CFG_SAMPLE_BYTES);

  // Restoring division step on the magnitude of the frame sum.
  assign trial = {rem_q, dq_q[SumW-1]};
  assign fits  = trial >= {2'b00, nch};

  always_comb begin
    sample_shift_d = sample_shift_q;
    byte_idx_d     = byte_idx_q;
    ch_idx_d       = ch_idx_q;
    frame_sum_d    = frame_sum_q;
    frames_done_d  = frames_done_q;
    dq_d           = dq_q;
    rem_d          = rem_q;
    neg_d          = neg_q;
    last_d         = last_q;
    cnt_d          = cnt_q;

    if (cmd_i.take && !limited) begin
      if (!sample_end) begin
        sample_shift_d = shift_new;
        byte_idx_d     = byte_idx_q + 2'd1;
      end else begin
        sample_shift_d = '0;
        byte_idx_d     = '0;
        if (!frame_end) begin
          ch_idx_d    = ch_idx_q + 4'd1;
          frame_sum_d = sum_new;
        end else begin
          ch_idx_d      = '0;
          frame_sum_d   = '0;
          frames_done_d = frames_done_q + 32'd1;
          last_d        = (frames_done_q + 32'd1) == frame_limit_q;
          neg_d         = sum_new[SumW-1];
          dq_d          = sum_new[SumW-1] ? SumW'(-sum_new) : SumW'(sum_new);
          rem_d         = '0;
          cnt_d         = CntLoad;
        end
      end
    end

    if (cmd_i.div_step) begin
      rem_d = fits ? 5'(trial - {2'b00, nch}) : trial[4:0];
      dq_d  = {dq_q[SumW-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
    end

    if (cfg_clear) begin
      sample_shift_d = '0;
      byte_idx_d     = '0;
      ch_idx_d       = '0;
      frame_sum_d    = '0;
    end
  end

  assign quot_signed = neg_q ? (~dq_q + SumW'(1)) : dq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= 4'd1;
      sample_bytes_q  <= 3'd2;
      frame_limit_q   <= '0;
      sample_shift_q  <= '0;
      byte_idx_q      <= '0;
      ch_idx_q        <= '0;
      frame_sum_q     <= '0;
      frames_done_q   <= '0;
      cnt_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CHANNEL_COUNT: channel_count_q <= cfg_wdata_i[3:0];
          CFG_SAMPLE_BYTES:  sample_bytes_q  <= cfg_wdata_i[2:0];
          CFG_FRAME_LIMIT:   frame_limit_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      sample_shift_q <= sample_shift_d;
      byte_idx_q     <= byte_idx_d;
      ch_idx_q       <= ch_idx_d;
      frame_sum_q    <= frame_sum_d;
      frames_done_q  <= frames_done_d;
      cnt_q          <= cnt_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    last_q <= last_d;
    if (cmd_i.out_load) begin
      out_sample_q <= quot_signed[SampleW-1:0];
      out_last_q   <= last_q;
    end
  end

  assign status_o.frame_end = frame_end;
  assign status_o.div_last  = cnt_q == '0;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign mono_sample_o = out_sample_q;
  assign last_frame_o  = out_last_q;

endmodule
